[hdl/srsw_pkg.sv]
package srsw_pkg;

    // window geometry and retry policy
    localparam int WINDOW_SLOTS = 16;
    localparam int RETRY_LIMIT  = 5;
    localparam int SLOT_W       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int WIN_CAP      = (WINDOW_SLOTS < 16) ? WINDOW_SLOTS : 16;

    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(WINDOW_SLOTS);

    // field widths
    localparam int SEQ_W   = 32;
    localparam int WORD_W  = 32;
    localparam int AGE_W   = 17;
    localparam int RTRY_W  = 4;
    localparam int WIN_W   = 5;
    localparam int TMO_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [AGE_W-1:0]  AGE_MAX  = '1;
    localparam logic [RTRY_W-1:0] RTRY_MAX = '1;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 136;
    localparam int M_TUSER_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } srsw_op_t;

    typedef enum logic [2:0] {
        EV_SENT    = 3'd0,
        EV_FULL    = 3'd1,
        EV_ACK     = 3'd2,
        EV_IGNORED = 3'd3,
        EV_RETX    = 3'd4,
        EV_GIVEUP  = 3'd5,
        EV_IDLE    = 3'd6
    } srsw_ev_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SLIDE,
        ST_EMIT
    } srsw_state_t;

    typedef struct packed {
        logic in_load;
        logic do_send;
        logic ev_full;
        logic do_ack;
        logic ev_ign;
        logic tick_start;
        logic ev_idle;
        logic scan_hit;
        logic scan_skip;
        logic slide_step;
        logic out_load;
    } srsw_cmd_t;

    typedef struct packed {
        srsw_op_t op;
        logic     win_full;
        logic     ack_ok;
        logic     fire_any;
        logic     fire_left;
        logic     cur_fire;
        logic     slide_more;
        logic     out_free;
        logic     ev_last;
    } srsw_stat_t;

    // ring index arithmetic, both operands below WINDOW_SLOTS
    function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= SLOTS_X) begin
            sum = sum - SLOTS_X;
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(logic [SLOT_W-1:0] a);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + (SLOT_W + 1)'(1);
        if (sum >= SLOTS_X) begin
            sum = '0;
        end
        return sum[SLOT_W-1:0];
    endfunction

    // distance from b forward to a around the ring
    function automatic logic [SLOT_W-1:0] slot_dist(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] d;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b};
        end else begin
            d = {1'b0, a} + SLOTS_X - {1'b0, b};
        end
        return d[SLOT_W-1:0];
    endfunction

endpackage

[hdl/srsw_ctrl.sv]
module srsw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  srsw_pkg::srsw_stat_t stat,
    output srsw_pkg::srsw_cmd_t  cmd
);
    import srsw_pkg::*;

    srsw_state_t state_reg;
    srsw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (stat.op)
                    OP_SEND: state_next = ST_EMIT;
                    OP_ACK:  state_next = stat.ack_ok ? ST_SLIDE : ST_EMIT;
                    OP_TICK: state_next = stat.fire_any ? ST_SCAN : ST_EMIT;
                    OP_NOP:  state_next = ST_EMIT;
                endcase
            end
            ST_SCAN: begin
                if (stat.cur_fire) begin
                    state_next = ST_SLIDE;
                end
            end
            ST_SLIDE: begin
                if (!stat.slide_more) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = stat.ev_last ? ST_IDLE : ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
            end
            ST_EXEC: begin
                unique case (stat.op)
                    OP_SEND: begin
                        cmd.ev_full = stat.win_full;
                        cmd.do_send = !stat.win_full;
                    end
                    OP_ACK: begin
                        cmd.do_ack = stat.ack_ok;
                        cmd.ev_ign = !stat.ack_ok;
                    end
                    OP_TICK: begin
                        cmd.tick_start = 1'b1;
                        cmd.ev_idle    = !stat.fire_any;
                    end
                    OP_NOP: begin
                        cmd.ev_idle = 1'b1;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan_hit  = stat.cur_fire;
                cmd.scan_skip = !stat.cur_fire;
            end
            ST_SLIDE: begin
                cmd.slide_step = stat.slide_more;
            end
            ST_EMIT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> stat.fire_left)
        else $error("scan running with no timed-out slot left");

    a_more_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && stat.out_free && !stat.ev_last |=> stat.fire_left)
        else $error("non-final beat sent but no further event pending");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && !stat.out_free |=> state_reg == ST_EMIT)
        else $error("result dropped while output stage was busy");
`endif

endmodule

[hdl/srsw_dp.sv]
module srsw_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [srsw_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [srsw_pkg::S_TUSER_W-1:0]      s_tuser,
    input  srsw_pkg::srsw_cmd_t                 cmd,
    output srsw_pkg::srsw_stat_t                stat,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [srsw_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [srsw_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);
    import srsw_pkg::*;

    // configuration
    logic [WIN_W-1:0] win_reg;
    logic [TMO_W-1:0] tmo_reg;

    // window pointers
    logic [SEQ_W-1:0]  next_reg;
    logic [SEQ_W-1:0]  base_reg;
    logic [SLOT_W-1:0] head_reg;

    // slot store
    logic [WINDOW_SLOTS-1:0] pend_reg;
    logic [WORD_W-1:0]       pay_reg  [WINDOW_SLOTS];
    logic [AGE_W-1:0]        age_reg  [WINDOW_SLOTS];
    logic [RTRY_W-1:0]       rtry_reg [WINDOW_SLOTS];

    // latched input beat
    srsw_op_t          op_reg;
    logic [WORD_W-1:0] pay_in_reg;
    logic [SEQ_W-1:0]  ackn_reg;
    logic              flag_reg;

    // tick scan
    logic [WINDOW_SLOTS-1:0] fire_reg;
    logic [SLOT_W-1:0]       idx_reg;
    logic [SLOT_W-1:0]       tick_head_reg;
    logic [SEQ_W-1:0]        tick_base_reg;

    // pending result
    srsw_ev_t          ev_code_reg;
    logic [SEQ_W-1:0]  ev_seq_reg;
    logic [WORD_W-1:0] ev_pay_reg;
    logic [RTRY_W-1:0] ev_att_reg;
    logic              ev_last_reg;

    // output stage
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic                 m_tlast_reg;

    logic [SEQ_W-1:0]        occ;
    logic [WIN_W-1:0]        eff_win;
    logic [SEQ_W-1:0]        ack_off;
    logic                    ack_ok;
    logic [SLOT_W-1:0]       ack_slot;
    logic [SLOT_W-1:0]       send_slot;
    logic [SLOT_W-1:0]       cur_slot;
    logic [SLOT_W-1:0]       rd_slot;
    logic [RTRY_W-1:0]       rd_rtry;
    logic [RTRY_W-1:0]       rtry_new;
    logic                    gives_up;
    logic [SEQ_W-1:0]        seq_cur;
    logic [WINDOW_SLOTS-1:0] cur_onehot;
    logic                    cur_last;
    logic [AGE_W-1:0]        aged     [WINDOW_SLOTS];
    logic [WINDOW_SLOTS-1:0] in_rng;
    logic [WINDOW_SLOTS-1:0] fire_vec;

    always_comb begin
        occ       = next_reg - base_reg;
        eff_win   = (win_reg > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : win_reg;
        ack_off   = ackn_reg - base_reg;
        ack_ok    = flag_reg && (ack_off < occ);
        ack_slot  = slot_add(head_reg, ack_off[SLOT_W-1:0]);
        send_slot = slot_add(head_reg, occ[SLOT_W-1:0]);
        cur_slot  = slot_add(tick_head_reg, idx_reg);
        rd_slot   = (op_reg == OP_TICK) ? cur_slot : ack_slot;
        rd_rtry   = rtry_reg[rd_slot];
        rtry_new  = (rd_rtry == RTRY_MAX) ? RTRY_MAX : rd_rtry + RTRY_W'(1);
        gives_up  = rtry_new > RTRY_W'(RETRY_LIMIT);
        seq_cur   = tick_base_reg + SEQ_W'(idx_reg);
        cur_onehot = WINDOW_SLOTS'(1) << cur_slot;
        cur_last   = (fire_reg & ~cur_onehot) == '0;
    end

    // per-slot aging and timeout check, all slots side by side
    always_comb begin
        for (int s = 0; s < WINDOW_SLOTS; s++) begin
            aged[s]     = (age_reg[s] == AGE_MAX) ? AGE_MAX : age_reg[s] + AGE_W'(1);
            in_rng[s]   = {1'b0, slot_dist(SLOT_W'(s), head_reg)} < occ[SLOT_W:0];
            fire_vec[s] = pend_reg[s] && in_rng[s] && (aged[s] > {1'b0, tmo_reg});
        end
    end

    always_comb begin
        stat            = '0;
        stat.op         = op_reg;
        stat.win_full   = occ >= SEQ_W'(eff_win);
        stat.ack_ok     = ack_ok;
        stat.fire_any   = |fire_vec;
        stat.fire_left  = |fire_reg;
        stat.cur_fire   = fire_reg[cur_slot];
        stat.slide_more = (base_reg != next_reg) && !pend_reg[head_reg];
        stat.out_free   = !m_tvalid_reg || m_tready;
        stat.ev_last    = ev_last_reg;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= WIN_W'(4);
            tmo_reg      <= TMO_W'(100);
            next_reg     <= '0;
            base_reg     <= '0;
            head_reg     <= '0;
            pend_reg     <= '0;
            fire_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_WINDOW_SIZE:   win_reg <= cfg_wdata[WIN_W-1:0];
                    REG_TIMEOUT_TICKS: tmo_reg <= cfg_wdata[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.do_send) begin
                pend_reg[send_slot] <= 1'b1;
                next_reg            <= next_reg + SEQ_W'(1);
            end
            if (cmd.do_ack) begin
                pend_reg[ack_slot] <= 1'b0;
            end
            if (cmd.tick_start) begin
                fire_reg <= fire_vec;
            end
            if (cmd.scan_hit) begin
                fire_reg[cur_slot] <= 1'b0;
                if (gives_up) begin
                    pend_reg[cur_slot] <= 1'b0;
                end
            end
            if (cmd.slide_step) begin
                base_reg <= base_reg + SEQ_W'(1);
                head_reg <= slot_inc(head_reg);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // slot contents
    always_ff @(posedge aclk) begin
        if (cmd.do_send) begin
            pay_reg[send_slot]  <= pay_in_reg;
            age_reg[send_slot]  <= '0;
            rtry_reg[send_slot] <= '0;
        end
        if (cmd.tick_start) begin
            for (int s = 0; s < WINDOW_SLOTS; s++) begin
                if (pend_reg[s] && in_rng[s]) begin
                    age_reg[s] <= aged[s];
                end
            end
        end
        if (cmd.scan_hit) begin
            rtry_reg[cur_slot] <= rtry_new;
            if (!gives_up) begin
                age_reg[cur_slot] <= '0;
            end
        end
    end

    // input latch, scan bookkeeping, result assembly
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg     <= srsw_op_t'(s_tuser[1:0]);
            flag_reg   <= s_tuser[2];
            pay_in_reg <= s_tdata[WORD_W-1:0];
            ackn_reg   <= s_tdata[WORD_W+SEQ_W-1:WORD_W];
        end
        if (cmd.tick_start) begin
            idx_reg       <= '0;
            tick_head_reg <= head_reg;
            tick_base_reg <= base_reg;
        end
        if (cmd.scan_hit || cmd.scan_skip) begin
            idx_reg <= idx_reg + SLOT_W'(1);
        end
        if (cmd.ev_full) begin
            ev_code_reg <= EV_FULL;
            ev_seq_reg  <= next_reg;
            ev_pay_reg  <= '0;
            ev_att_reg  <= '0;
            ev_last_reg <= 1'b1;
        end
        if (cmd.do_send) begin
            ev_code_reg <= EV_SENT;
            ev_seq_reg  <= next_reg;
            ev_pay_reg  <= pay_in_reg;
            ev_att_reg  <= '0;
            ev_last_reg <= 1'b1;
        end
        if (cmd.do_ack) begin
            ev_code_reg <= EV_ACK;
            ev_seq_reg  <= ackn_reg;
            ev_pay_reg  <= '0;
            ev_att_reg  <= rd_rtry;
            ev_last_reg <= 1'b1;
        end
        if (cmd.ev_ign) begin
            ev_code_reg <= EV_IGNORED;
            ev_seq_reg  <= ackn_reg;
            ev_pay_reg  <= '0;
            ev_att_reg  <= '0;
            ev_last_reg <= 1'b1;
        end
        if (cmd.ev_idle) begin
            ev_code_reg <= EV_IDLE;
            ev_seq_reg  <= base_reg;
            ev_pay_reg  <= '0;
            ev_att_reg  <= '0;
            ev_last_reg <= 1'b1;
        end
        if (cmd.scan_hit) begin
            ev_code_reg <= gives_up ? EV_GIVEUP : EV_RETX;
            ev_seq_reg  <= seq_cur;
            ev_pay_reg  <= gives_up ? '0 : pay_reg[cur_slot];
            ev_att_reg  <= rtry_new;
            ev_last_reg <= cur_last;
        end
        if (cmd.out_load) begin
            m_tuser_reg <= M_TUSER_W'(ev_code_reg);
            m_tlast_reg <= ev_last_reg;
            m_tdata_reg <= M_TDATA_W'({next_reg, base_reg, ev_att_reg, ev_pay_reg, ev_seq_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_reg - base_reg) <= SEQ_W'(WIN_CAP))
        else $error("more packets in flight than the window holds");

    a_slide_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.slide_step |-> base_reg != next_reg)
        else $error("base moved past next sequence");

    a_fire_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire_reg & ~pend_reg) == '0)
        else $error("timed-out mark on a slot that is not pending");
`endif

endmodule

[hdl/selective_repeat_sender_window.sv]
// send, ignored ack and idle commands: decoded in the exec state, result loaded into the output
// register from the emit state once it is free; the next command beat is accepted back in idle
// accepted ack: the base then slides over the cleared slots (0 to 16) before the result is emitted
// tick: an idle result when nothing has timed out; else the scan walks the slots up to the last
// timed-out one (up to 16), emitting each retransmit or give-up after any base slide it causes
// reset: synchronous active low; window and pending marks cleared at once, no clearing pass
module selective_repeat_sender_window (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srsw_pkg::S_TDATA_W-1:0]  s_tdata,   // payload[31:0], ack_number[63:32]
    input  logic [srsw_pkg::S_TUSER_W-1:0]  s_tuser,   // command[1:0], ack_flag[2]
    // event stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srsw_pkg::M_TDATA_W-1:0]  m_tdata,   // seq_number[31:0], out_payload[63:32],
                                                       // attempt[67:64], window_base[99:68],
                                                       // next_sequence[131:100], zero pad
    output logic [srsw_pkg::M_TUSER_W-1:0]  m_tuser,   // event_res[2:0]
    output logic                            m_tlast    // final beat of this command
);
    import srsw_pkg::*;

    // command and status between sequencer and window datapath
    srsw_cmd_t  cmd;
    srsw_stat_t stat;

    // sequencer: decode, tick scan walk, base slide, beat hand-off
    srsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: config, window pointers, slot store, output register
    srsw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[verif/selective_repeat_sender_window_test.sv]
module selective_repeat_sender_window_test;

    import srsw_pkg::*;

    // run limits: the bound covers every command with all its event beats under receiver stalls,
    // plus sender gaps, one long hold-off and the settle pauses, several times over
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 100;   // longest tick scan with slides, with margin
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int PHASE_CMDS    = 64;
    localparam int NUM_PHASES    = 6;

    // one command beat as driven on the input stream
    typedef struct {
        srsw_op_t    op;
        logic [31:0] word;
        logic [31:0] ack_no;
        logic        ack_flag;
    } command_t;

    // one event beat as seen on the output stream
    typedef struct {
        srsw_ev_t    ev;
        logic [31:0] seq;
        logic [31:0] word;
        logic [3:0]  tries;
        logic [31:0] base;
        logic [31:0] nxt;
        logic        last;
    } window_event_t;

    // mirror of the sender window: predicts the event beats of each accepted command
    class sender_window_tracker;
        logic [4:0]       win_reg;
        logic [15:0]      tmo_reg;
        logic [31:0]      next_seq;
        logic [31:0]      base_seq;
        int               head;
        logic             pend  [WINDOW_SLOTS];
        logic [31:0]      word  [WINDOW_SLOTS];
        logic [AGE_W-1:0] age   [WINDOW_SLOTS];
        logic [3:0]       tries [WINDOW_SLOTS];
        window_event_t    pending_events[$];
        int               mismatches;

        function new();
            win_reg  = 5'd4;
            tmo_reg  = 16'd100;
            next_seq = '0;
            base_seq = '0;
            head     = 0;
            mismatches = 0;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                pend[i]  = 1'b0;
                word[i]  = '0;
                age[i]   = '0;
                tries[i] = '0;
            end
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_WINDOW_SIZE) begin
                win_reg = value[4:0];
            end else begin
                tmo_reg = value[15:0];
            end
        endfunction

        // window size saturated to the ring
        function int unsigned window_cap();
            int unsigned w;
            w = win_reg;
            if (w > 16) w = 16;
            if (w > WINDOW_SLOTS) w = WINDOW_SLOTS;
            return w;
        endfunction

        function int slot_of(logic [31:0] seq);
            logic [31:0] d;
            d = seq - base_seq;
            return int'((32'(head) + d) % WINDOW_SLOTS);
        endfunction

        // move base past every cleared slot
        function void slide_base();
            while (base_seq != next_seq && !pend[head]) begin
                base_seq = base_seq + 1;
                head = (head + 1) % WINDOW_SLOTS;
            end
        endfunction

        function void push_event(srsw_ev_t ev, logic [31:0] seq, logic [31:0] pay,
                                 logic [3:0] att);
            window_event_t e;
            e.ev    = ev;
            e.seq   = seq;
            e.word  = pay;
            e.tries = att;
            e.base  = base_seq;
            e.nxt   = next_seq;
            e.last  = 1'b0;
            pending_events.push_back(e);
        endfunction

        // apply one accepted command and queue the beats it must produce
        function void accept_command(command_t c);
            int          first;
            int          s;
            logic [31:0] span;
            logic [31:0] start;
            logic [31:0] seq;
            logic [31:0] cnt;
            logic [3:0]  att;
            first = pending_events.size();
            span  = next_seq - base_seq;
            case (c.op)
                OP_SEND: begin
                    if (span >= window_cap()) begin
                        push_event(EV_FULL, next_seq, '0, '0);
                    end else begin
                        s = slot_of(next_seq);
                        seq = next_seq;
                        pend[s]  = 1'b1;
                        word[s]  = c.word;
                        age[s]   = '0;
                        tries[s] = '0;
                        next_seq = next_seq + 1;
                        push_event(EV_SENT, seq, c.word, '0);
                    end
                end
                OP_ACK: begin
                    if (c.ack_flag && (c.ack_no - base_seq) < span) begin
                        s = slot_of(c.ack_no);
                        att = tries[s];
                        pend[s] = 1'b0;
                        if (c.ack_no == base_seq) slide_base();
                        push_event(EV_ACK, c.ack_no, '0, att);
                    end else begin
                        // not an ack, or outside the window
                        push_event(EV_IGNORED, c.ack_no, '0, '0);
                    end
                end
                OP_TICK: begin
                    start = base_seq;
                    cnt = (span > WINDOW_SLOTS) ? 32'(WINDOW_SLOTS) : span;
                    for (int i = 0; i < cnt && (pending_events.size() - first) < 16; i++) begin
                        seq = start + 32'(i);
                        if ((seq - base_seq) >= (next_seq - base_seq)) continue;
                        s = slot_of(seq);
                        if (!pend[s]) continue;
                        if (age[s] != AGE_MAX) age[s] = age[s] + 1;
                        if (age[s] > tmo_reg) begin
                            if (tries[s] != RTRY_MAX) tries[s] = tries[s] + 1;
                            if (tries[s] > RETRY_LIMIT) begin
                                pend[s] = 1'b0;
                                if (seq == base_seq) slide_base();
                                push_event(EV_GIVEUP, seq, '0, tries[s]);
                            end else begin
                                age[s] = '0;
                                push_event(EV_RETX, seq, word[s], tries[s]);
                            end
                        end
                    end
                    if (pending_events.size() == first) push_event(EV_IDLE, base_seq, '0, '0);
                end
                default: begin
                    push_event(EV_IDLE, base_seq, '0, '0);
                end
            endcase
            pending_events[pending_events.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        // check one accepted event beat against the oldest prediction
        function void match_event(logic [M_TUSER_W-1:0] user, logic [M_TDATA_W-1:0] data,
                                  logic last);
            window_event_t e;
            if (pending_events.size() == 0) begin
                $error("unexpected event beat: event %0d seq %0h", user, data[31:0]);
                mismatches++;
                return;
            end
            e = pending_events.pop_front();
            compare_field("event_res", 32'(e.ev), 32'(user[2:0]));
            compare_field("seq_number", e.seq, data[31:0]);
            compare_field("out_payload", e.word, data[63:32]);
            compare_field("attempt", 32'(e.tries), 32'(data[67:64]));
            compare_field("window_base", e.base, data[99:68]);
            compare_field("next_sequence", e.nxt, data[131:100]);
            compare_field("last", 32'(e.last), 32'(last));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // payload[31:0], ack_number[63:32]
    logic [S_TUSER_W-1:0]  s_tuser;    // command[1:0], ack_flag[2]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // seq_number, out_payload, attempt, window_base,
                                       // next_sequence, zero pad
    logic [M_TUSER_W-1:0]  m_tuser;    // event_res[2:0]
    logic                  m_tlast;

    sender_window_tracker tracker;

    // knobs shared between the stimulus and the receiver, and the watchdog count
    logic gaps_on = 1'b1;
    int   holds_asked = 0;
    int   cycle_count = 0;

    selective_repeat_sender_window dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // event beats are sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.match_event(m_tuser, m_tdata, m_tlast);
        end
    end

    // receiver: random stall bursts, one long hold-off on request, none when gaps are off
    initial begin
        int holds_done;
        holds_done = 0;
        forever begin
            if (holds_done != holds_asked) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    function automatic command_t make_cmd(srsw_op_t op, logic [31:0] word,
                                          logic [31:0] ack_no, logic flag);
        command_t c;
        c.op       = op;
        c.word     = word;
        c.ack_no   = ack_no;
        c.ack_flag = flag;
        return c;
    endfunction

    // mostly well-formed traffic: sends, acks inside the window (often of base), ticks;
    // a little noise of stray acks, non-ack packets and the spare command
    function automatic command_t random_cmd();
        command_t    c;
        logic [31:0] span;
        int unsigned r;
        c = make_cmd(OP_SEND, $urandom, $urandom, 1'($urandom_range(0, 1)));
        span = tracker.next_seq - tracker.base_seq;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            c.op = OP_SEND;
        end else if (r < 72) begin
            if (span != 0) begin
                c.op = OP_ACK;
                c.ack_flag = 1'b1;
                if ($urandom_range(0, 1) == 0) begin
                    c.ack_no = tracker.base_seq;
                end else begin
                    c.ack_no = tracker.base_seq + $urandom_range(0, span - 1);
                end
            end
        end else if (r < 92) begin
            c.op = OP_TICK;
        end else if (r < 95) begin
            c.op = OP_ACK;    // stray number, either flag
        end else if (r < 98) begin
            c.op = OP_ACK;
            c.ack_flag = 1'b0;
            c.ack_no = tracker.base_seq + $urandom_range(0, 3);
        end else begin
            c.op = OP_NOP;
        end
        return c;
    endfunction

    // drive one command beat; starts and ends at a falling edge with tvalid still high
    task automatic run_cmd(input command_t c);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.ack_no, c.word};
        s_tuser  <= {c.ack_flag, c.op};
        do @(posedge aclk); while (!s_tready);
        tracker.accept_command(c);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        tracker.configure(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // stop offering, wait for every predicted beat, then let a tick scan finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [4:0]  phase_win [NUM_PHASES];
        logic [15:0] phase_tmo [NUM_PHASES];
        phase_win = '{5'd16, 5'd1, 5'd31, 5'd7, 5'd3, 5'd16};
        phase_tmo = '{16'd0, 16'd2, 16'd65535, 16'd4, 16'd1, 16'd6};
        tracker = new();
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset settings (window 4, timeout 100)
        run_cmd(make_cmd(OP_NOP, '1, '1, 1'b1));            // spare command reports idle
        run_cmd(make_cmd(OP_TICK, '0, '0, 1'b0));           // tick with nothing pending
        run_cmd(make_cmd(OP_SEND, '0, '0, 1'b0));
        run_cmd(make_cmd(OP_SEND, '1, '1, 1'b1));
        run_cmd(make_cmd(OP_SEND, 32'ha5a5a5a5, '0, 1'b0));
        run_cmd(make_cmd(OP_SEND, 32'h5a5a5a5a, '0, 1'b0));
        run_cmd(make_cmd(OP_SEND, 32'h1, '0, 1'b0));        // window full
        run_cmd(make_cmd(OP_ACK, '0, 32'd0, 1'b0));         // not an ack packet
        run_cmd(make_cmd(OP_ACK, '0, 32'd2, 1'b1));         // inside, not base: no slide
        run_cmd(make_cmd(OP_ACK, '0, 32'd2, 1'b1));         // already cleared, accepted again
        run_cmd(make_cmd(OP_ACK, '0, '1, 1'b1));            // far outside the window
        run_cmd(make_cmd(OP_ACK, '0, 32'd0, 1'b1));         // base moves by one
        run_cmd(make_cmd(OP_ACK, '0, 32'd1, 1'b1));         // base slides over the cleared slot
        run_cmd(make_cmd(OP_ACK, '0, 32'd7, 1'b1));         // beyond next sequence
        settle();

        // window of zero, immediate timeout
        cfg_write(REG_WINDOW_SIZE, 16'd0);
        cfg_write(REG_TIMEOUT_TICKS, 16'd0);
        run_cmd(make_cmd(OP_SEND, 32'h12345678, '0, 1'b0));
        run_cmd(make_cmd(OP_TICK, '0, '0, 1'b0));
        settle();

        // oversized window saturates; ticks walk retransmits into give-ups
        cfg_write(REG_WINDOW_SIZE, 16'd31);
        run_cmd(make_cmd(OP_SEND, 32'hdeadbeef, '0, 1'b0));
        run_cmd(make_cmd(OP_SEND, 32'h0badf00d, '0, 1'b0));
        repeat (7) run_cmd(make_cmd(OP_TICK, '1, '1, 1'b1));

        // random phases, one setting each; the last one runs without gaps
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            cfg_write(REG_WINDOW_SIZE, 16'(phase_win[p]));
            cfg_write(REG_TIMEOUT_TICKS, phase_tmo[p]);
            gaps_on = (p != NUM_PHASES - 1);
            if (p == 0) holds_asked++;    // receiver stalls long while commands keep coming
            for (int n = 0; n < PHASE_CMDS; n++) begin
                if (p == 1 && n == PHASE_CMDS / 2) settle();    // sender drains fully
                run_cmd(random_cmd());
            end
        end

        settle();
        if (tracker.mismatches == 0 && tracker.pending_events.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
